// ===== rtl/core/cds_pkg.sv =====
// Shared types, codes and calendar helpers for the calendar date stepper.
// Used by cds_ctrl, cds_datapath and calendar_date_stepper_core.
package cds_pkg;

   // Fixed field widths.
   localparam int DAY_W   = 5;
   localparam int MONTH_W = 4;
   localparam int CNT_W   = 16;
   localparam int MOD_W   = 9;   // holds a year modulo 400

   // Year reduction: the year without its four low bits (at most 28 bits) is
   // divided by 25 with a reciprocal multiplication. Only the low bits of the
   // quotient are kept, since the remainder is below 32.
   localparam int                 Z_W         = 28;
   localparam int                 RECIP_W     = 29;
   localparam int                 RECIP_SHIFT = 33;
   localparam int                 QLO_W       = 5;
   localparam logic [RECIP_W-1:0] RECIP_25    = 29'd343597384;  // ceil(2^33 / 25)

   localparam logic [MOD_W:0]     YEAR_CYCLE  = 10'd400;
   localparam logic [MOD_W-1:0]   CYCLE_LAST  = 9'd399;
   localparam logic [MOD_W-1:0]   CENTURY_1   = 9'd100;
   localparam logic [MOD_W-1:0]   CENTURY_2   = 9'd200;
   localparam logic [MOD_W-1:0]   CENTURY_3   = 9'd300;
   localparam logic [MONTH_W-1:0] MONTH_FIRST = 4'd1;
   localparam logic [MONTH_W-1:0] MONTH_FEB   = 4'd2;
   localparam logic [MONTH_W-1:0] MONTH_LAST  = 4'd12;
   localparam logic [DAY_W-1:0]   DAY_FIRST   = 5'd1;
   localparam logic [DAY_W-1:0]   DAY_DEC_END = 5'd31;

   typedef enum logic [2:0] {
      CMD_SET  = 3'd0,
      CMD_NEXT = 3'd1,
      CMD_PREV = 3'd2,
      CMD_ADD  = 3'd3,
      CMD_SUB  = 3'd4
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_REDUCE,
      ST_CHECK,
      ST_STEP,
      ST_DONE
   } ctrl_state_type;

   // Controller to datapath.
   typedef struct packed {
      logic capture;   // take a new request word
      logic reduce;    // one step of the year modulo 400 reduction
      logic apply;     // validate and apply a set
      logic step;      // one day step
   } dp_cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic reduce_last;  // this is the last cycle of the year reduction
      logic count_zero;   // no day steps remain
      logic blocked;      // the next day step would cross a date limit
   } dp_status_type;

   // Days in a month; zero for a month code outside 1..12.
   function automatic logic [DAY_W-1:0] month_length(input logic [MONTH_W-1:0] month,
                                                      input logic leap);
      logic [DAY_W-1:0] len;
      case (month)
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
         4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
         MONTH_FEB:                                  len = leap ? 5'd29 : 5'd28;
         default:                                    len = 5'd0;
      endcase
      return len;
   endfunction

   // Leap year from the year modulo 400 and the year's two low bits.
   function automatic logic leap_year(input logic [MOD_W-1:0] ymod,
                                      input logic [1:0] low_bits);
      return (ymod == '0) ||
             ((low_bits == 2'b00) && (ymod != CENTURY_1) &&
              (ymod != CENTURY_2) && (ymod != CENTURY_3));
   endfunction

endpackage

// ===== rtl/core/cds_ctrl.sv =====
// Controller state machine for the calendar date stepper.
// Depends on cds_pkg; drives cds_datapath through command and status structs.
module cds_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  cds_pkg::cmd_type       req_cmd,
   input  logic                   out_free,
   input  cds_pkg::dp_status_type status,
   output cds_pkg::dp_cmd_type    dp_cmd,
   output logic                   idle,
   output logic                   out_load
);

   cds_pkg::ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cds_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      dp_cmd   = '0;
      idle     = 1'b0;
      out_load = 1'b0;
      case (state_ff)
         cds_pkg::ST_IDLE: begin
            idle = 1'b1;
            if (req_valid) begin
               dp_cmd.capture = 1'b1;
               case (req_cmd)
                  cds_pkg::CMD_SET: state_in = cds_pkg::ST_REDUCE;
                  cds_pkg::CMD_NEXT,
                  cds_pkg::CMD_PREV,
                  cds_pkg::CMD_ADD,
                  cds_pkg::CMD_SUB: state_in = cds_pkg::ST_STEP;
                  default:          state_in = cds_pkg::ST_DONE;
               endcase
            end
         end
         cds_pkg::ST_REDUCE: begin
            dp_cmd.reduce = 1'b1;
            if (status.reduce_last) begin
               state_in = cds_pkg::ST_CHECK;
            end
         end
         cds_pkg::ST_CHECK: begin
            dp_cmd.apply = 1'b1;
            state_in     = cds_pkg::ST_DONE;
         end
         cds_pkg::ST_STEP: begin
            if (status.count_zero) begin
               state_in = cds_pkg::ST_DONE;
            end else begin
               dp_cmd.step = 1'b1;
               if (status.blocked) begin
                  state_in = cds_pkg::ST_DONE;
               end
            end
         end
         cds_pkg::ST_DONE: begin
            if (out_free) begin
               out_load = 1'b1;
               state_in = cds_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = cds_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

// ===== rtl/core/cds_datapath.sv =====
// Datapath of the calendar date stepper: date registers, year modulo 400
// tracking, reciprocal year reduction for set and the day step logic. Uses cds_pkg.
module cds_datapath #(
   parameter int YEAR_BITS = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  cds_pkg::dp_cmd_type            dp_cmd,
   input  cds_pkg::cmd_type               req_cmd,
   input  logic [cds_pkg::DAY_W-1:0]      req_set_day,
   input  logic [cds_pkg::MONTH_W-1:0]    req_set_month,
   input  logic [YEAR_BITS-1:0]           req_set_year,
   input  logic [cds_pkg::CNT_W-1:0]      req_day_count,
   output cds_pkg::dp_status_type         status,
   output logic [cds_pkg::DAY_W-1:0]      cur_day,
   output logic [cds_pkg::MONTH_W-1:0]    cur_month,
   output logic [YEAR_BITS-1:0]           cur_year,
   output logic                           cur_accepted,
   output logic                           cur_held
);

   localparam logic [YEAR_BITS-1:0] YEAR_MAX = '1;
   localparam logic [YEAR_BITS-1:0] YEAR_ONE = YEAR_BITS'(1);
   localparam int PROD_W = cds_pkg::Z_W + cds_pkg::RECIP_W;

   // Request word.
   cds_pkg::cmd_type                cmd_ff;
   logic [cds_pkg::DAY_W-1:0]       sd_ff;
   logic [cds_pkg::MONTH_W-1:0]     sm_ff;
   logic [YEAR_BITS-1:0]            sy_ff;
   logic [cds_pkg::CNT_W-1:0]       cnt_ff, cnt_in;
   logic                            phase_ff, phase_in;
   logic [cds_pkg::QLO_W-1:0]       quot_ff, quot_in;
   logic [cds_pkg::MOD_W-1:0]       rem_ff, rem_in;

   // Date state.
   logic [cds_pkg::DAY_W-1:0]       day_ff, day_in;
   logic [cds_pkg::MONTH_W-1:0]     month_ff, month_in;
   logic [YEAR_BITS-1:0]            year_ff, year_in;
   logic [cds_pkg::MOD_W-1:0]       ymod_ff, ymod_in;
   logic                            accepted_ff, accepted_in;
   logic                            held_ff, held_in;

   logic [cds_pkg::Z_W-1:0]         sy_hi;
   logic [PROD_W-1:0]               prod;
   logic [cds_pkg::QLO_W-1:0]       quot_x25;
   logic [cds_pkg::QLO_W-1:0]       rem25;
   logic                            set_leap;
   logic [cds_pkg::DAY_W-1:0]       set_last;
   logic                            set_ok;
   logic                            cur_leap;
   logic [cds_pkg::DAY_W-1:0]       cur_last;
   logic [cds_pkg::DAY_W-1:0]       prev_last;
   logic                            forward;
   logic                            blocked;

   assign forward  = (cmd_ff == cds_pkg::CMD_NEXT) || (cmd_ff == cds_pkg::CMD_ADD);
   assign cur_leap = cds_pkg::leap_year(ymod_ff, year_ff[1:0]);
   assign cur_last = cds_pkg::month_length(month_ff, cur_leap);
   assign prev_last = cds_pkg::month_length(month_ff - 4'd1, cur_leap);
   assign blocked  = forward ?
      ((day_ff >= cur_last) && (month_ff == cds_pkg::MONTH_LAST) && (year_ff == YEAR_MAX)) :
      ((day_ff <= cds_pkg::DAY_FIRST) && (month_ff == cds_pkg::MONTH_FIRST) &&
       (year_ff <= YEAR_ONE));

   // Year modulo 400 is 16 * ((year / 16) mod 25) + year mod 16. The first
   // reduce cycle registers the low quotient bits of (year / 16) / 25; the
   // second forms the remainder by 25, which fits in five bits, so five-bit
   // arithmetic is exact.
   assign sy_hi    = cds_pkg::Z_W'(sy_ff >> 4);
   assign prod     = PROD_W'(sy_hi) * PROD_W'(cds_pkg::RECIP_25);
   assign quot_x25 = {quot_ff[0], 4'b0} + {quot_ff[1:0], 3'b0} + quot_ff;
   assign rem25    = sy_hi[4:0] - quot_x25;

   assign set_leap = cds_pkg::leap_year(rem_ff, sy_ff[1:0]);
   assign set_last = cds_pkg::month_length(sm_ff, set_leap);
   assign set_ok   = (set_last != '0) && (sy_ff != '0) && (sd_ff != '0) &&
                     (sd_ff <= set_last);

   always_comb begin
      cnt_in      = cnt_ff;
      phase_in    = phase_ff;
      quot_in     = quot_ff;
      rem_in      = rem_ff;
      day_in      = day_ff;
      month_in    = month_ff;
      year_in     = year_ff;
      ymod_in     = ymod_ff;
      accepted_in = accepted_ff;
      held_in     = held_ff;

      if (dp_cmd.capture) begin
         phase_in = 1'b0;
         held_in  = 1'b0;
         case (req_cmd)
            cds_pkg::CMD_NEXT,
            cds_pkg::CMD_PREV: begin
               cnt_in      = cds_pkg::CNT_W'(1);
               accepted_in = 1'b1;
            end
            cds_pkg::CMD_ADD,
            cds_pkg::CMD_SUB: begin
               cnt_in      = req_day_count;
               accepted_in = 1'b1;
            end
            default: begin
               cnt_in      = '0;
               accepted_in = 1'b0;
            end
         endcase
      end

      if (dp_cmd.reduce) begin
         phase_in = 1'b1;
         if (phase_ff) begin
            rem_in = {rem25, sy_ff[3:0]};
         end else begin
            quot_in = prod[cds_pkg::RECIP_SHIFT +: cds_pkg::QLO_W];
         end
      end

      if (dp_cmd.apply) begin
         accepted_in = set_ok;
         if (set_ok) begin
            day_in   = sd_ff;
            month_in = sm_ff;
            year_in  = sy_ff;
            ymod_in  = rem_ff;
         end
      end

      if (dp_cmd.step) begin
         cnt_in = cnt_ff - cds_pkg::CNT_W'(1);
         if (blocked) begin
            held_in = 1'b1;
         end else if (forward) begin
            if (day_ff < cur_last) begin
               day_in = day_ff + 5'd1;
            end else if (month_ff != cds_pkg::MONTH_LAST) begin
               day_in   = cds_pkg::DAY_FIRST;
               month_in = month_ff + 4'd1;
            end else begin
               day_in   = cds_pkg::DAY_FIRST;
               month_in = cds_pkg::MONTH_FIRST;
               year_in  = year_ff + YEAR_ONE;
               ymod_in  = (ymod_ff == cds_pkg::CYCLE_LAST) ? '0 : ymod_ff + 9'd1;
            end
         end else begin
            if (day_ff > cds_pkg::DAY_FIRST) begin
               day_in = day_ff - 5'd1;
            end else if (month_ff != cds_pkg::MONTH_FIRST) begin
               month_in = month_ff - 4'd1;
               day_in   = prev_last;
            end else begin
               day_in   = cds_pkg::DAY_DEC_END;
               month_in = cds_pkg::MONTH_LAST;
               year_in  = year_ff - YEAR_ONE;
               ymod_in  = (ymod_ff == '0) ? cds_pkg::CYCLE_LAST : ymod_ff - 9'd1;
            end
         end
      end
   end

   // Request payload, no reset needed.
   always_ff @(posedge clock) begin
      if (dp_cmd.capture) begin
         cmd_ff <= req_cmd;
         sd_ff  <= req_set_day;
         sm_ff  <= req_set_month;
         sy_ff  <= req_set_year;
      end
      cnt_ff   <= cnt_in;
      phase_ff <= phase_in;
      quot_ff  <= quot_in;
      rem_ff   <= rem_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         day_ff      <= cds_pkg::DAY_FIRST;
         month_ff    <= cds_pkg::MONTH_FIRST;
         year_ff     <= YEAR_ONE;
         ymod_ff     <= 9'd1;
         accepted_ff <= 1'b0;
         held_ff     <= 1'b0;
      end else begin
         day_ff      <= day_in;
         month_ff    <= month_in;
         year_ff     <= year_in;
         ymod_ff     <= ymod_in;
         accepted_ff <= accepted_in;
         held_ff     <= held_in;
      end
   end

   assign status.reduce_last = phase_ff;
   assign status.count_zero  = (cnt_ff == '0);
   assign status.blocked     = blocked;

   assign cur_day      = day_ff;
   assign cur_month    = month_ff;
   assign cur_year     = year_ff;
   assign cur_accepted = accepted_ff;
   assign cur_held     = held_ff;

   a_ymod_range: assert property (@(posedge clock) disable iff (reset)
      ymod_ff < cds_pkg::YEAR_CYCLE[cds_pkg::MOD_W-1:0])
      else $error("year modulo 400 out of range");

   a_date_sane: assert property (@(posedge clock) disable iff (reset)
      (year_ff != '0) && (day_ff != '0) && (month_ff != '0) &&
      (month_ff <= cds_pkg::MONTH_LAST))
      else $error("current date holds an impossible value");

   a_step_counted: assert property (@(posedge clock) disable iff (reset)
      dp_cmd.step |-> (cnt_ff != '0))
      else $error("day step taken with no steps remaining");

endmodule

// ===== rtl/core/calendar_date_stepper_core.sv =====
// Calendar date stepper top level; depends on cds_pkg, cds_ctrl and cds_datapath.
// A set runs the reduce, check and done states; the stepping commands run step and
// done, one day step per cycle until the count runs out or a date limit stops it;
// a spare command code goes straight to done. One word in flight: a new request is
// taken the cycle after the result is loaded; a stalled response holds it back.
// Reset (synchronous, active high) sets the date to 1 January of year 1.
module calendar_date_stepper_core #(
   parameter int YEAR_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,

   // Request channel.
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [2:0]                    req_cmd,
   input  logic [cds_pkg::DAY_W-1:0]     req_set_day,
   input  logic [cds_pkg::MONTH_W-1:0]   req_set_month,
   input  logic [YEAR_BITS-1:0]          req_set_year,
   input  logic [cds_pkg::CNT_W-1:0]     req_day_count,

   // Response channel.
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [cds_pkg::DAY_W-1:0]     rsp_out_day,
   output logic [cds_pkg::MONTH_W-1:0]   rsp_out_month,
   output logic [YEAR_BITS-1:0]          rsp_out_year,
   output logic                          rsp_accepted,
   output logic                          rsp_held
);

   // A request word is taken only while the controller is idle. Each word
   // walks through the controller: a set first reduces the year modulo 400
   // with a reciprocal multiplication so the leap rule can be checked, then
   // validates; day steps run one per cycle out of a down counter. The finished
   // date lands in the response register, which can hold a result while the
   // next request is already being worked on.

   cds_pkg::dp_cmd_type          dp_cmd;
   cds_pkg::dp_status_type       dp_status;
   cds_pkg::cmd_type             cmd_code;
   logic                         idle;
   logic                         out_load;
   logic                         out_free;

   logic [cds_pkg::DAY_W-1:0]    cur_day;
   logic [cds_pkg::MONTH_W-1:0]  cur_month;
   logic [YEAR_BITS-1:0]         cur_year;
   logic                         cur_accepted;
   logic                         cur_held;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic [cds_pkg::DAY_W-1:0]    day_ff;
   logic [cds_pkg::MONTH_W-1:0]  month_ff;
   logic [YEAR_BITS-1:0]         year_ff;
   logic                         accepted_ff;
   logic                         held_ff;

   assign cmd_code  = cds_pkg::cmd_type'(req_cmd);
   assign req_stall = !idle;

   // The response register can take a new result when it is empty or when
   // its current word leaves in this cycle.
   assign out_free = !rsp_valid_ff || !rsp_stall;

   cds_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_cmd   (cmd_code),
      .out_free  (out_free),
      .status    (dp_status),
      .dp_cmd    (dp_cmd),
      .idle      (idle),
      .out_load  (out_load)
   );

   cds_datapath #(
      .YEAR_BITS (YEAR_BITS)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .dp_cmd        (dp_cmd),
      .req_cmd       (cmd_code),
      .req_set_day   (req_set_day),
      .req_set_month (req_set_month),
      .req_set_year  (req_set_year),
      .req_day_count (req_day_count),
      .status        (dp_status),
      .cur_day       (cur_day),
      .cur_month     (cur_month),
      .cur_year      (cur_year),
      .cur_accepted  (cur_accepted),
      .cur_held      (cur_held)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Response payload needs no reset; it is qualified by the valid flag.
   always_ff @(posedge clock) begin
      if (out_load) begin
         day_ff      <= cur_day;
         month_ff    <= cur_month;
         year_ff     <= cur_year;
         accepted_ff <= cur_accepted;
         held_ff     <= cur_held;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_day   = day_ff;
   assign rsp_out_month = month_ff;
   assign rsp_out_year  = year_ff;
   assign rsp_accepted  = accepted_ff;
   assign rsp_held      = held_ff;

   // A limit hold only happens on a stepping command, which is always applied.
   a_held_accepted: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_held |-> rsp_accepted)
      else $error("response reports a hold on a rejected command");

   // A result is never loaded over one that is still stalled.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      out_load |-> !(rsp_valid_ff && rsp_stall))
      else $error("response register overwritten while stalled");

   // A loaded result is offered on the next cycle.
   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      out_load |=> rsp_valid)
      else $error("loaded result not presented");

endmodule

// ===== test/calendar_date_stepper_core_tb.sv =====
// Self-checking testbench for calendar_date_stepper_core: a queued driver, a
// monitor with its own calendar predictor, random idling on both channels.
// Depends on cds_pkg and the calendar_date_stepper_core RTL.
`timescale 1ns / 100ps

module calendar_date_stepper_core_tb;

   localparam int          YEAR_W    = 16;
   localparam int unsigned LAST_YEAR = (1 << YEAR_W) - 1;
   // Generous bound on cycles without any handshake: the longest add or
   // subtract walks 65535 days one per cycle, and then the result may stall.
   localparam int          WATCHDOG_LIMIT = 300000;
   // Cycles to linger after the last result to catch stray result words.
   localparam int          TAIL_CYCLES = YEAR_W + 10;

   // Command codes that the block does not define; they must change nothing.
   localparam logic [2:0]  CMD_SPARE_5 = 3'd5;
   localparam logic [2:0]  CMD_SPARE_6 = 3'd6;
   localparam logic [2:0]  CMD_SPARE_7 = 3'd7;

   typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_type;

   // One request word plus a flag that makes the driver hold it back until
   // every result owed so far has come out.
   typedef struct {
      logic [2:0]                  cmd;
      logic [cds_pkg::DAY_W-1:0]   day;
      logic [cds_pkg::MONTH_W-1:0] month;
      logic [YEAR_W-1:0]           year;
      logic [cds_pkg::CNT_W-1:0]   count;
      bit                          drain_first;
   } date_word_type;

   typedef struct {
      logic [cds_pkg::DAY_W-1:0]   day;
      logic [cds_pkg::MONTH_W-1:0] month;
      logic [YEAR_W-1:0]           year;
      logic                        accepted;
      logic                        held;
   } date_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                          req_valid     = 1'b0;
   logic                          req_stall;
   logic [2:0]                    req_cmd       = cds_pkg::CMD_NEXT;
   logic [cds_pkg::DAY_W-1:0]     req_set_day   = '0;
   logic [cds_pkg::MONTH_W-1:0]   req_set_month = '0;
   logic [YEAR_W-1:0]             req_set_year  = '0;
   logic [cds_pkg::CNT_W-1:0]     req_day_count = '0;

   logic                          rsp_valid;
   logic                          rsp_stall     = 1'b0;
   logic [cds_pkg::DAY_W-1:0]     rsp_out_day;
   logic [cds_pkg::MONTH_W-1:0]   rsp_out_month;
   logic [YEAR_W-1:0]             rsp_out_year;
   logic                          rsp_accepted;
   logic                          rsp_held;

   calendar_date_stepper_core #(.YEAR_BITS(YEAR_W)) dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_cmd       (req_cmd),
      .req_set_day   (req_set_day),
      .req_set_month (req_set_month),
      .req_set_year  (req_set_year),
      .req_day_count (req_day_count),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_day   (rsp_out_day),
      .rsp_out_month (rsp_out_month),
      .rsp_out_year  (rsp_out_year),
      .rsp_accepted  (rsp_accepted),
      .rsp_held      (rsp_held)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
   end

   // ---------------------------------------------------------------------
   // Calendar predictor. It keeps its own copy of the date, which starts at
   // 1 January of year 1 just as the block does after reset.
   // ---------------------------------------------------------------------
   int unsigned cal_day   = 1;
   int unsigned cal_month = 1;
   int unsigned cal_year  = 1;

   function automatic bit is_leap_year(int unsigned y);
      return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
   endfunction

   // Zero for a month outside 1..12, which marks a set with such a month as invalid.
   function automatic int unsigned days_in(int unsigned m, int unsigned y);
      case (m)
         1, 3, 5, 7, 8, 10, 12: return 31;
         4, 6, 9, 11:           return 30;
         2:                     return is_leap_year(y) ? 29 : 28;
         default:               return 0;
      endcase
   endfunction

   // One day forward; returns 0 when the date sits on the last day of the
   // largest year and cannot move.
   function automatic bit day_forward();
      if (cal_day < days_in(cal_month, cal_year)) begin
         cal_day++;
      end else if (cal_month != 12) begin
         cal_day = 1;
         cal_month++;
      end else if (cal_year >= LAST_YEAR) begin
         return 1'b0;
      end else begin
         cal_day   = 1;
         cal_month = 1;
         cal_year++;
      end
      return 1'b1;
   endfunction

   // One day back; returns 0 at 1 January of year 1.
   function automatic bit day_backward();
      if (cal_day > 1) begin
         cal_day--;
      end else if (cal_month != 1) begin
         cal_month--;
         cal_day = days_in(cal_month, cal_year);
      end else if (cal_year <= 1) begin
         return 1'b0;
      end else begin
         cal_day   = 31;
         cal_month = 12;
         cal_year--;
      end
      return 1'b1;
   endfunction

   // Applies one request word to the predicted date and returns the result
   // word the block must produce for it.
   function automatic date_result_type advance_calendar(date_word_type w);
      date_result_type r;
      int unsigned     last;
      r.accepted = 1'b0;
      r.held     = 1'b0;
      case (w.cmd)
         cds_pkg::CMD_SET: begin
            last = days_in(32'(w.month), 32'(w.year));
            if (last != 0 && w.year >= 1 && w.day >= 1 && w.day <= last) begin
               cal_day    = 32'(w.day);
               cal_month  = 32'(w.month);
               cal_year   = 32'(w.year);
               r.accepted = 1'b1;
            end
         end
         cds_pkg::CMD_NEXT: begin
            r.accepted = 1'b1;
            r.held     = !day_forward();
         end
         cds_pkg::CMD_PREV: begin
            r.accepted = 1'b1;
            r.held     = !day_backward();
         end
         cds_pkg::CMD_ADD: begin
            r.accepted = 1'b1;
            // The walk stops at the first blocked step; the rest is dropped.
            for (int unsigned i = 0; i < w.count && !r.held; i++)
               r.held = !day_forward();
         end
         cds_pkg::CMD_SUB: begin
            r.accepted = 1'b1;
            for (int unsigned i = 0; i < w.count && !r.held; i++)
               r.held = !day_backward();
         end
         default: ;   // Spare codes leave the date alone and are not accepted.
      endcase
      r.day   = cds_pkg::DAY_W'(cal_day);
      r.month = cds_pkg::MONTH_W'(cal_month);
      r.year  = YEAR_W'(cal_year);
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Stimulus generation.
   // ---------------------------------------------------------------------
   date_word_type word_backlog[$];

   task automatic queue_word(logic [2:0] cmd, int unsigned day, int unsigned month,
                             int unsigned year, int unsigned count, bit drain_first = 1'b0);
      date_word_type w;
      w.cmd         = cmd;
      w.day         = cds_pkg::DAY_W'(day);
      w.month       = cds_pkg::MONTH_W'(month);
      w.year        = YEAR_W'(year);
      w.count       = cds_pkg::CNT_W'(count);
      w.drain_first = drain_first;
      word_backlog.push_back(w);
   endtask

   // Years are drawn so that both date limits and the century rule come up
   // often, while the full 16-bit range still gets covered.
   function automatic int unsigned pick_year();
      int unsigned pick;
      int unsigned y;
      pick = $urandom_range(0, 9);
      if (pick < 4) begin
         y = $urandom_range(1, LAST_YEAR);
      end else if (pick < 6) begin
         y = $urandom_range(LAST_YEAR - 5, LAST_YEAR);
      end else if (pick < 8) begin
         y = $urandom_range(1, 5);
      end else begin
         y = $urandom_range(0, 163) * 400 + $urandom_range(0, 3) * 100 + $urandom_range(0, 1);
         if (y == 0)
            y = 400;
      end
      return y;
   endfunction

   // Step counts are mostly short so that the run stays brief; a few walk a
   // long way and reach the upper bits of the count.
   function automatic int unsigned pick_count();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 60)
         return $urandom_range(0, 40);
      else if (pick < 85)
         return $urandom_range(41, 400);
      else if (pick < 97)
         return $urandom_range(401, 2000);
      else
         return $urandom_range(2001, (1 << cds_pkg::CNT_W) - 1);
   endfunction

   task automatic queue_random_word(bit drain_first);
      int unsigned pick;
      int unsigned y;
      int unsigned m;
      logic [2:0]  cmd;
      // Fields that the command ignores carry random values anyway.
      int unsigned junk_day;
      int unsigned junk_month;
      int unsigned junk_year;
      int unsigned junk_count;
      pick       = $urandom_range(0, 99);
      junk_day   = $urandom_range(0, 31);
      junk_month = $urandom_range(0, 15);
      junk_year  = $urandom_range(0, LAST_YEAR);
      junk_count = $urandom_range(0, (1 << cds_pkg::CNT_W) - 1);
      if (pick < 25) begin
         y = pick_year();
         m = $urandom_range(1, 12);
         queue_word(cds_pkg::CMD_SET, $urandom_range(1, days_in(m, y)), m, y, junk_count,
                    drain_first);
      end else if (pick < 32) begin
         queue_word(cds_pkg::CMD_SET, junk_day, junk_month, junk_year, junk_count,
                    drain_first);
      end else if (pick < 50) begin
         queue_word(cds_pkg::CMD_NEXT, junk_day, junk_month, junk_year, junk_count,
                    drain_first);
      end else if (pick < 68) begin
         queue_word(cds_pkg::CMD_PREV, junk_day, junk_month, junk_year, junk_count,
                    drain_first);
      end else if (pick < 81) begin
         queue_word(cds_pkg::CMD_ADD, junk_day, junk_month, junk_year, pick_count(),
                    drain_first);
      end else if (pick < 94) begin
         queue_word(cds_pkg::CMD_SUB, junk_day, junk_month, junk_year, pick_count(),
                    drain_first);
      end else if (pick < 97) begin
         cmd = 3'($urandom_range(CMD_SPARE_5, CMD_SPARE_7));
         queue_word(cmd, junk_day, junk_month, junk_year, junk_count, drain_first);
      end else if ($urandom_range(0, 1) == 0) begin
         // A few days above the lower limit.
         queue_word(cds_pkg::CMD_SET, $urandom_range(1, 3), cds_pkg::MONTH_FIRST, 1,
                    junk_count, drain_first);
      end else begin
         // A few days below the upper limit.
         queue_word(cds_pkg::CMD_SET, $urandom_range(28, 31), cds_pkg::MONTH_LAST,
                    LAST_YEAR, junk_count, drain_first);
      end
   endtask

   // ---------------------------------------------------------------------
   // Driver. It works through the backlog in bursts of random length with
   // random gaps, and holds a stalled word steady until it is taken.
   // ---------------------------------------------------------------------
   int unsigned   burst_left = 0;
   int unsigned   gap_left   = 0;
   date_word_type launch_word;
   bit            results_owed = 1'b0;   // registered by the monitor

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!(req_valid && req_stall)) begin
         // The previous word, if any, was taken at this edge.
         if (gap_left != 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (word_backlog.size() != 0 &&
                      !(word_backlog[0].drain_first && (results_owed || req_valid))) begin
            launch_word = word_backlog.pop_front();
            req_cmd       <= launch_word.cmd;
            req_set_day   <= launch_word.day;
            req_set_month <= launch_word.month;
            req_set_year  <= launch_word.year;
            req_day_count <= launch_word.count;
            req_valid     <= 1'b1;
            if (burst_left <= 1) begin
               // Now and then a long burst with no gap behind it.
               if ($urandom_range(0, 4) == 0) begin
                  burst_left = $urandom_range(30, 80);
                  gap_left   = 0;
               end else begin
                  burst_left = $urandom_range(1, 12);
                  gap_left   = $urandom_range(0, 6);
               end
            end else begin
               burst_left--;
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Receiver stall pattern: it switches between no stall, light and heavy
   // random stalls and a fixed periodic pattern, each for a random span.
   // ---------------------------------------------------------------------
   stall_mode_type stall_mode = STALL_NONE;
   int unsigned    stall_span = 0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (stall_span == 0) begin
            stall_mode = stall_mode_type'($urandom_range(0, 3));
            stall_span = $urandom_range(20, 300);
         end else begin
            stall_span--;
         end
         case (stall_mode)
            STALL_NONE:  rsp_stall <= 1'b0;
            STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
            default:     rsp_stall <= (stall_span % 5) < 2;
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Monitor. Each accepted request word runs through the predictor, and
   // each accepted result word is checked against the oldest prediction.
   // ---------------------------------------------------------------------
   date_result_type due_dates[$];
   date_result_type oldest_due;
   date_word_type   taken_word;
   int unsigned     mismatch_count = 0;

   task automatic check_field(string name, logic [31:0] expected_val, logic [31:0] actual_val);
      if (expected_val !== actual_val) begin
         $error("%s: expected %0d, got %0d", name, expected_val, actual_val);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         // Results are checked before the new request is predicted, so a
         // result that shows up with nothing owed is never excused.
         if (rsp_valid && !rsp_stall) begin
            if (due_dates.size() == 0) begin
               $error("result word with no request outstanding: %0d/%0d/%0d",
                      rsp_out_day, rsp_out_month, rsp_out_year);
               mismatch_count++;
            end else begin
               oldest_due = due_dates.pop_front();
               check_field("out_day",   32'(oldest_due.day),      32'(rsp_out_day));
               check_field("out_month", 32'(oldest_due.month),    32'(rsp_out_month));
               check_field("out_year",  32'(oldest_due.year),     32'(rsp_out_year));
               check_field("accepted",  32'(oldest_due.accepted), 32'(rsp_accepted));
               check_field("held",      32'(oldest_due.held),     32'(rsp_held));
            end
         end
         if (req_valid && !req_stall) begin
            taken_word.cmd   = req_cmd;
            taken_word.day   = req_set_day;
            taken_word.month = req_set_month;
            taken_word.year  = req_set_year;
            taken_word.count = req_day_count;
            due_dates.push_back(advance_calendar(taken_word));
         end
         results_owed <= (due_dates.size() != 0);
      end
   end

   // ---------------------------------------------------------------------
   // Watchdog: any handshake restarts the count.
   // ---------------------------------------------------------------------
   int unsigned quiet_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("timeout: no word moved for %0d cycles", WATCHDOG_LIMIT);
         $display("RESULT: ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus and end of run.
   // ---------------------------------------------------------------------
   initial begin
      // Lower limit straight out of reset: every backward step is blocked,
      // and a zero count is accepted without being held.
      queue_word(cds_pkg::CMD_PREV, 0, 0, 0, 0);
      queue_word(cds_pkg::CMD_SUB, 31, 15, LAST_YEAR, 5);
      queue_word(cds_pkg::CMD_ADD, 0, 0, 0, 0);
      // Upper limit: largest date fields, then forward steps that hold. The
      // full count is dropped at the first blocked step.
      queue_word(cds_pkg::CMD_SET, cds_pkg::DAY_DEC_END, cds_pkg::MONTH_LAST, LAST_YEAR, 0);
      queue_word(cds_pkg::CMD_NEXT, 0, 0, 0, 0);
      queue_word(cds_pkg::CMD_ADD, 0, 0, 0, (1 << cds_pkg::CNT_W) - 1);
      queue_word(cds_pkg::CMD_SUB, 0, 0, 0, 3, 1'b1);
      queue_word(cds_pkg::CMD_ADD, 0, 0, 0, 10);
      // Leap years: divisible by 400 is leap, a plain century is not.
      queue_word(cds_pkg::CMD_SET, 29, cds_pkg::MONTH_FEB, 2000, 0);
      queue_word(cds_pkg::CMD_SET, 29, cds_pkg::MONTH_FEB, 1900, 0);
      queue_word(cds_pkg::CMD_SET, 29, cds_pkg::MONTH_FEB, 2024, 0);
      queue_word(cds_pkg::CMD_NEXT, 0, 0, 0, 0);
      queue_word(cds_pkg::CMD_PREV, 0, 0, 0, 0);
      // Invalid sets: day zero, day past the month end, month zero or above
      // twelve, year zero. The date must stay at 29 February 2024.
      queue_word(cds_pkg::CMD_SET, 0, 5, 100, 0);
      queue_word(cds_pkg::CMD_SET, 31, 4, 100, 0);
      queue_word(cds_pkg::CMD_SET, 15, 0, 10, 0);
      queue_word(cds_pkg::CMD_SET, 15, 15, 10, 0);
      queue_word(cds_pkg::CMD_SET, 10, 6, 0, 0);
      // Spare command codes.
      queue_word(CMD_SPARE_5, 1, 1, 1, 7);
      queue_word(CMD_SPARE_6, 31, 12, LAST_YEAR, 0);
      queue_word(CMD_SPARE_7, 0, 0, 0, (1 << cds_pkg::CNT_W) - 1);
      // Year and month boundaries, and a long subtract that hits the bottom.
      queue_word(cds_pkg::CMD_SET, 31, cds_pkg::MONTH_LAST, 1999, 0);
      queue_word(cds_pkg::CMD_NEXT, 0, 0, 0, 0);
      queue_word(cds_pkg::CMD_SET, 1, 3, 2100, 0);
      queue_word(cds_pkg::CMD_PREV, 0, 0, 0, 0);
      queue_word(cds_pkg::CMD_SET, 1, cds_pkg::MONTH_FIRST, 2, 0);
      queue_word(cds_pkg::CMD_SUB, 0, 0, 0, (1 << cds_pkg::CNT_W) - 1);

      // Random part. Every hundredth word also waits for the pipe to empty.
      for (int i = 0; i < 650; i++)
         queue_random_word(i % 100 == 50);

      // Wait for the backlog to drain and every owed result to arrive. The
      // polling happens on the falling edge, away from the driving edge.
      @(negedge clock);
      while (word_backlog.size() != 0 || req_valid || due_dates.size() != 0)
         @(negedge clock);
      // Catch any stray result words that trail the last one.
      repeat (TAIL_CYCLES) @(negedge clock);

      if (mismatch_count == 0 && due_dates.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
